### src/mrr_pkg.sv
// Shared types and constants of the matrix ring rotation block.
package mrr_pkg;

  // Field and register widths fixed by the interface
  localparam int DIM_W     = 7;   // rows and cols registers
  localparam int POS_W     = 6;   // row and col fields
  localparam int ROT_W     = 16;  // rotation register
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Coordinate and ring-position arithmetic; also holds a perimeter of up to 504
  localparam int CW    = 9;
  // Dividend of the ring modulo: ring position plus rotation
  localparam int DVD_W = ROT_W + 1;
  localparam int CNT_W = $clog2(DVD_W + 1);

  localparam logic [DIM_W-1:0] DIM_RST = 7'd2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT  = 2'd2;

  // Operation codes carried on in_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Read sequencer states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_GEOM  = 7'b0000100,
    ST_POS   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_MAP   = 7'b0100000,
    ST_RESP  = 7'b1000000
  } mrr_state_t;

endpackage

### src/mrr_mod.sv
// Iterative restoring remainder unit: one dividend bit per cycle.
module mrr_mod (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [mrr_pkg::DVD_W-1:0] dividend,
  input  logic [mrr_pkg::CW-1:0]    divisor,
  output logic                     done,
  output logic [mrr_pkg::CW-1:0]    rem
);
  import mrr_pkg::*;

  logic [DVD_W-1:0] dvd_r;
  logic [CW-1:0]    div_r;
  logic [CW-1:0]    rem_r;
  logic [CW-1:0]    rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [CW:0]      rem_sh;
  logic [CW:0]      diff;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    diff    = rem_sh - {1'b0, div_r};
    rem_nxt = (rem_sh >= {1'b0, div_r}) ? diff[CW-1:0] : rem_sh[CW-1:0];
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### src/matrix_ring_rotate_top.sv
// Matrix ring rotation: element store with rotated reads by address arithmetic.
//
// Writes (in_tuser = 0) store the value at (row, col). A rotated read (in_tuser = 1)
// of an element on a full ring steps through range check, ring geometry and ring
// position, then the bit-serial remainder unit (17 dividend bits and a completion
// step) that reduces (position + rotation) modulo the ring perimeter, then the store
// read and the load of the output register, which raises out_tvalid. Reads outside
// the matrix go from the range check straight to the output load, and reads of the
// centre line go from the range check straight to the store read, skipping the
// remainder unit. The block takes no new item while a read is in flight and is ready
// again the cycle after the result is loaded; a result still waiting in the output
// register holds the next read in its last step until that transfer. The store has
// no reset; reading an element never written returns an arbitrary value.
// Configuration writes are always taken and must only be issued while the block is
// idle.
module matrix_ring_rotate_top #(
  parameter int MAX_DIM     = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input item
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // in_tdata: row [5:0], col [11:6], value [VALUE_WIDTH+11:12], zero fill above
  input  logic [((2*mrr_pkg::POS_W+VALUE_WIDTH+7)/8)*8-1:0] in_tdata,
  // in_tuser: operation [0]
  input  logic                                   in_tuser,
  // Result item
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // out_tdata: value_res [VALUE_WIDTH-1:0], zero fill above
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]       out_tdata,
  // Configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mrr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mrr_pkg::CFG_DAT_W-1:0]          cfg_data
);
  import mrr_pkg::*;

  localparam int IW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int MEM_DEPTH = 1 << (2 * IW);
  localparam int OUT_W     = ((VALUE_WIDTH + 7) / 8) * 8;

  function automatic logic [CW-1:0] min2(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [CW-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [CW-1:0] dw;
    dw = CW'(d);
    if (dw < CW'(2)) return CW'(2);
    if (dw > CW'(MAX_DIM)) return CW'(MAX_DIM);
    return dw;
  endfunction

  // Configuration registers
  logic [DIM_W-1:0] rows_r, cols_r;
  logic [ROT_W-1:0] rot_r;

  // Sequencer and per-read working registers
  mrr_state_t       state_r, state_nxt;
  logic [CW-1:0]    row_r, col_r, nr_r, nc_r, k_r;
  logic [CW-1:0]    bot_r, right_r, h_r, w_r, len_r;
  logic             zero_r, center_r;

  // Store and output registers
  logic [VALUE_WIDTH-1:0] mem_r [MEM_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic [VALUE_WIDTH-1:0] out_data_r;
  logic                   out_valid_r;

  // Input fields
  logic                   in_acc;
  logic [CW-1:0]          in_row, in_col;
  logic [VALUE_WIDTH-1:0] in_value;

  // Combinational helpers
  logic [CW-1:0]     nr_c, nc_c, k_c;
  logic              zero_c, center_c;
  logic [CW-1:0]     h_c, w_c;
  logic [CW-1:0]     p_c;
  logic [DVD_W-1:0]  dvd_c;
  logic [CW-1:0]     sr_c, sc_c, q_off;
  logic [2*IW-1:0]   wr_addr, rd_addr;
  logic              wr_en, rd_en, out_free;
  logic              div_start, div_done;
  logic [CW-1:0]     div_rem;

  assign in_row   = CW'(in_tdata[POS_W-1:0]);
  assign in_col   = CW'(in_tdata[2*POS_W-1:POS_W]);
  assign in_value = in_tdata[2*POS_W+VALUE_WIDTH-1:2*POS_W];
  assign in_acc   = in_tvalid && in_tready;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_RST;
      cols_r <= DIM_RST;
      rot_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS: rows_r <= cfg_data[DIM_W-1:0];
        CFG_COLS: cols_r <= cfg_data[DIM_W-1:0];
        CFG_ROT:  rot_r  <= cfg_data[ROT_W-1:0];
        default:  ;
      endcase
    end
  end

  // Range check and ring index of the requested element
  always_comb begin
    nr_c     = clamp_dim(rows_r);
    nc_c     = clamp_dim(cols_r);
    zero_c   = (row_r >= nr_c) || (col_r >= nc_c);
    k_c      = min2(min2(row_r, col_r),
                    min2(nr_c - CW'(1) - row_r, nc_c - CW'(1) - col_r));
    center_c = (k_c >= (min2(nr_c, nc_c) >> 1));
  end

  // Ring height and width
  assign h_c = nr_r - CW'(1) - (k_r << 1);
  assign w_c = nc_r - CW'(1) - (k_r << 1);

  // Position of the element along its ring
  always_comb begin
    if (row_r == k_r) begin
      p_c = col_r - k_r;
    end else if (col_r == right_r) begin
      p_c = w_r + (row_r - k_r);
    end else if (row_r == bot_r) begin
      p_c = w_r + h_r + (right_r - col_r);
    end else begin
      p_c = (w_r << 1) + h_r + (bot_r - row_r);
    end
    dvd_c = DVD_W'(p_c) + DVD_W'(rot_r);
  end

  // Map the reduced ring position back to a row and column
  always_comb begin
    q_off = '0;
    if (div_rem < w_r) begin
      sr_c = k_r;
      sc_c = k_r + div_rem;
    end else if (div_rem < w_r + h_r) begin
      q_off = div_rem - w_r;
      sr_c  = k_r + q_off;
      sc_c  = right_r;
    end else if (div_rem < (w_r << 1) + h_r) begin
      q_off = div_rem - w_r - h_r;
      sr_c  = bot_r;
      sc_c  = right_r - q_off;
    end else begin
      q_off = div_rem - (w_r << 1) - h_r;
      sr_c  = bot_r - q_off;
      sc_c  = k_r;
    end
  end

  assign wr_en   = in_acc && (in_tuser == OP_WRITE) &&
                   (in_row < CW'(MAX_DIM)) && (in_col < CW'(MAX_DIM));
  assign wr_addr = {in_row[IW-1:0], in_col[IW-1:0]};
  assign rd_en   = (state_r == ST_MAP);
  assign rd_addr = center_r ? {row_r[IW-1:0], col_r[IW-1:0]}
                            : {sr_c[IW-1:0], sc_c[IW-1:0]};

  // Element store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= in_value;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Remainder unit
  assign div_start = (state_r == ST_POS);

  mrr_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_c),
    .divisor  (len_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign out_free = !out_valid_r || out_tready;

  // Advance the read sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == OP_READ)) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        if (zero_c)        state_nxt = ST_RESP;
        else if (center_c) state_nxt = ST_MAP;
        else               state_nxt = ST_GEOM;
      end
      ST_GEOM: state_nxt = ST_POS;
      ST_POS:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) state_nxt = ST_MAP;
      end
      ST_MAP:  state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request and its ring geometry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_r <= in_row;
      col_r <= in_col;
    end
    if (state_r == ST_SETUP) begin
      nr_r     <= nr_c;
      nc_r     <= nc_c;
      k_r      <= k_c;
      zero_r   <= zero_c;
      center_r <= center_c;
    end
    if (state_r == ST_GEOM) begin
      bot_r   <= nr_r - CW'(1) - k_r;
      right_r <= nc_r - CW'(1) - k_r;
      h_r     <= h_c;
      w_r     <= w_c;
      len_r   <= (h_c + w_c) << 1;
    end
  end

  // Output register: hold the result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_RESP) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_RESP) && out_free) begin
      out_data_r <= zero_r ? '0 : rd_data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

  // Remainder unit finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("remainder done outside divide state");

  // Reduced ring position lies on the ring
  a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (div_rem < len_r))
    else $error("ring remainder not below perimeter");

  // An accepted read starts the sequencer
  a_read_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == OP_READ)) |=> (state_r == ST_SETUP))
    else $error("read transfer did not start sequencer");

  // A write leaves the block ready for the next item
  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == OP_WRITE)) |=> (state_r == ST_IDLE))
    else $error("write transfer left idle state");

  // A result appears only after the response state
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_RESP))
    else $error("result raised outside response state");

endmodule

### tb/matrix_ring_rotate_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the matrix ring rotation block: rotated reads against a predictor.
module matrix_ring_rotate_top_tb;
  import mrr_pkg::*;

  localparam int VW         = 32;
  localparam int MDIM       = 64;
  localparam int IN_W       = ((2*POS_W+VW+7)/8)*8;
  localparam int OUT_W      = ((VW+7)/8)*8;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 30;
  localparam int HOLD_AT    = 150;
  localparam int HOLD_LEN   = 600;
  localparam int PEND_DEPTH = 8;

  // Expected rotated reads and the element store they are drawn from
  class rotation_checker;
    logic [VW-1:0]    cells [MDIM*MDIM];
    bit               written [MDIM*MDIM];
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    logic [ROT_W-1:0] rot_reg;
    logic [VW-1:0]    pend_vals [PEND_DEPTH];
    int unsigned      pend_wr;
    int unsigned      pend_rd;
    int               errors;

    function new();
      rows_reg = DIM_RST;
      cols_reg = DIM_RST;
      rot_reg  = '0;
      pend_wr  = 0;
      pend_rd  = 0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_ROWS: rows_reg = data[DIM_W-1:0];
        CFG_COLS: cols_reg = data[DIM_W-1:0];
        CFG_ROT:  rot_reg  = data[ROT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned dim_in_use(logic [DIM_W-1:0] d);
      if (d < 2) return 2;
      if (d > MDIM) return MDIM;
      return d;
    endfunction

    // Results still owed by the block
    function int unsigned pending_count();
      return pend_wr - pend_rd;
    endfunction

    function void queue_value(logic [VW-1:0] v);
      pend_vals[pend_wr % PEND_DEPTH] = v;
      pend_wr++;
    endfunction

    function logic [VW-1:0] take_value();
      logic [VW-1:0] v;
      v = pend_vals[pend_rd % PEND_DEPTH];
      pend_rd++;
      return v;
    endfunction

    // Map a read position to the store address it returns; 0 when outside the matrix
    function bit source_addr(int unsigned r, int unsigned c, output int unsigned addr);
      int unsigned nr, nc, ring, top, left, bottom, right, h, w, perim, p, q, sr, sc;
      nr = dim_in_use(rows_reg);
      nc = dim_in_use(cols_reg);
      addr = 0;
      if (r >= nr || c >= nc) return 0;
      ring = (r < c) ? r : c;
      if (nr - 1 - r < ring) ring = nr - 1 - r;
      if (nc - 1 - c < ring) ring = nc - 1 - c;
      // centre line belongs to no full ring
      if (ring >= ((nr < nc) ? nr : nc) / 2) begin
        addr = r * MDIM + c;
        return 1;
      end
      top    = ring;
      left   = ring;
      bottom = nr - 1 - ring;
      right  = nc - 1 - ring;
      h      = bottom - top;
      w      = right - left;
      perim  = 2 * (h + w);
      if (r == top) p = c - left;
      else if (c == right) p = w + (r - top);
      else if (r == bottom) p = w + h + (right - c);
      else p = 2 * w + h + (bottom - r);
      q = (p + rot_reg) % perim;
      if (q < w) begin
        sr = top;
        sc = left + q;
      end else if (q < w + h) begin
        sr = top + (q - w);
        sc = right;
      end else if (q < 2 * w + h) begin
        sr = bottom;
        sc = right - (q - w - h);
      end else begin
        sr = bottom - (q - 2 * w - h);
        sc = left;
      end
      addr = sr * MDIM + sc;
      return 1;
    endfunction

    // Store a write, or queue the value a read must return
    function void note_item(logic op, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                            logic [VW-1:0] val);
      int unsigned a;
      if (op == OP_WRITE) begin
        cells[r * MDIM + c]   = val;
        written[r * MDIM + c] = 1'b1;
      end else if (source_addr(r, c, a)) begin
        queue_value(cells[a]);
      end else begin
        queue_value('0);
      end
    endfunction

    function void report(string what, logic [VW-1:0] want, logic [VW-1:0] got);
      errors++;
      if (errors <= 10)
        $display("%0t %s: expected %h got %h", $realtime, what, want, got);
    endfunction

    function void check_value(logic [VW-1:0] got);
      logic [VW-1:0] want;
      if (pending_count() == 0) begin
        report("result with nothing pending", 'x, got);
        return;
      end
      want = take_value();
      if (got !== want) report("value_res mismatch", want, got);
    endfunction
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata   = '0;
  logic                 in_tuser   = OP_WRITE;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_ROWS;
  logic [CFG_DAT_W-1:0] cfg_data   = '0;

  rotation_checker sb = new();
  int idle_cycles = 0;
  int items_sent  = 0;
  int results_got = 0;
  int burst_left  = 0;
  bit steady      = 1'b0;

  matrix_ring_rotate_top #(
    .MAX_DIM    (MDIM),
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: check each transfer, stall on a pattern of its own
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit hold_done;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_value(out_tdata[VW-1:0]);
        results_got++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && results_got == HOLD_AT) begin
        // long hold-off so the block backs up into its input
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(0, 1);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Drop valid for a random gap at the start of each burst
  task automatic pace();
    int gap;
    if (!steady && burst_left == 0) begin
      gap        = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_item(logic op, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                           logic [VW-1:0] val);
    pace();
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_W-2*POS_W-VW){1'b0}}, val, c, r};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, r, c, val);
    items_sent++;
  endtask

  // Write the source element first when it was never written
  task automatic read_at(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
    int unsigned a;
    if (sb.source_addr(r, c, a) && !sb.written[a])
      send_item(OP_WRITE, POS_W'(a / MDIM), POS_W'(a % MDIM), $urandom());
    send_item(OP_READ, r, c, $urandom());
  endtask

  // Hold the input until every result is back and the block is quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_regs(int unsigned nrows, int unsigned ncols, int unsigned nrot);
    logic [CFG_IDX_W-1:0] idxs [3];
    logic [CFG_DAT_W-1:0] vals [3];
    idxs[0] = CFG_ROWS;
    idxs[1] = CFG_COLS;
    idxs[2] = CFG_ROT;
    vals[0] = CFG_DAT_W'(nrows);
    vals[1] = CFG_DAT_W'(ncols);
    vals[2] = CFG_DAT_W'(nrot);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(idxs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int unsigned nrows, int unsigned ncols, int unsigned nrot,
                           int count, bit no_gaps);
    int target;
    int unsigned nr, nc;
    logic [POS_W-1:0] r, c;
    drain();
    write_regs(nrows, ncols, nrot);
    steady = no_gaps;
    nr     = sb.dim_in_use(DIM_W'(nrows));
    nc     = sb.dim_in_use(DIM_W'(ncols));
    target = items_sent + count;
    while (items_sent < target) begin
      r = POS_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, MDIM-1)
                                             : $urandom_range(0, nr-1));
      c = POS_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, MDIM-1)
                                             : $urandom_range(0, nc-1));
      if ($urandom_range(0, 9) < 4)
        send_item(OP_WRITE, r, c, $urandom());
      else
        read_at(r, c);
    end
  endtask

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 127);
      1, 2:    return $urandom_range(2, 64);
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  function automatic int unsigned pick_rot();
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, 20);
      1:       return $urandom_range(0, 65535);
      default: return $urandom_range(0, 1) ? 65535 : 0;
    endcase
  endfunction

  initial begin
    int unsigned fixed_cfg [5][3];
    fixed_cfg = '{'{64, 64, 65535}, '{2, 64, 1}, '{64, 2, 2}, '{0, 1, 5}, '{127, 65, 65535}};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry 2x2, no rotation: extremes of value, reads outside the matrix
    send_item(OP_WRITE, 0, 0, 32'h8000_0000);
    send_item(OP_WRITE, 0, 1, 32'h7FFF_FFFF);
    send_item(OP_WRITE, 1, 1, 32'h0000_0000);
    send_item(OP_WRITE, 1, 0, 32'hFFFF_FFFF);
    read_at(0, 0);
    read_at(0, 1);
    read_at(1, 1);
    read_at(1, 0);
    read_at(2, 0);
    read_at(63, 63);
    // write outside the matrix in use is still stored
    send_item(OP_WRITE, 63, 63, 32'h5A5A_A5A5);

    // 3x5 with largest rotation: centre line stays put
    drain();
    write_regs(3, 5, 65535);
    send_item(OP_WRITE, 1, 1, $urandom());
    send_item(OP_WRITE, 1, 2, $urandom());
    send_item(OP_WRITE, 1, 3, $urandom());
    read_at(1, 2);
    read_at(0, 0);
    read_at(2, 4);

    // largest matrix picks up the earlier out-of-range write
    drain();
    write_regs(64, 64, 0);
    read_at(63, 63);
    read_at(0, 63);

    // out-of-range dimensions are clamped
    drain();
    write_regs(0, 127, 65535);
    read_at(1, 63);
    read_at(1, 0);

    // Random phases with fixed corner geometries first
    for (int ph = 0; ph < 14; ph++) begin
      if (ph < 5)
        run_phase(fixed_cfg[ph][0], fixed_cfg[ph][1], fixed_cfg[ph][2], 68, ph % 4 == 1);
      else
        run_phase(pick_dim(), pick_dim(), pick_rot(), 68, ph % 4 == 1);
    end

    drain();
    if (sb.pending_count() != 0) begin
      $display("%0d results never arrived", sb.pending_count());
      sb.errors += int'(sb.pending_count());
    end
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
